FILE: rtl/sat_pkg.sv
// Shared types, codes and helper functions for the shell argument tokenizer.
// No dependencies; the other RTL files except sat_if, and the testbench, take names from here by scope.
package sat_pkg;

  localparam int STACK_DEPTH = 6;
  localparam int QDEPTH      = 4;
  localparam int QAW         = 2;

  // Mode stack entry codes
  typedef logic [2:0] mode_t;
  localparam mode_t M_SKIPWS = 3'd0;
  localparam mode_t M_SQUOTE = 3'd1;
  localparam mode_t M_DQUOTE = 3'd2;
  localparam mode_t M_ESC    = 3'd3;
  localparam mode_t M_HEXHI  = 3'd4;
  localparam mode_t M_HEXLO  = 3'd5;
  localparam mode_t M_ARG    = 3'd6;

  // Result kinds
  localparam logic [1:0] K_BYTE   = 2'd0;
  localparam logic [1:0] K_ARGEND = 2'd1;
  localparam logic [1:0] K_BADHEX = 2'd2;
  localparam logic [1:0] K_DONE   = 2'd3;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [3:0] NIBBLE    = 4'hf;

  // All results caused by one input item; positions travel alongside.
  typedef struct packed {
    logic [1:0]       cnt;    // 1..3 when queued
    logic [2:0][1:0]  kinds;  // kinds[0] goes out first
    logic [7:0]       data;   // decoded byte, at most one per item
  } bundle_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h61 + 8'd10;
      return {1'b0, t[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h41 + 8'd10;
      return {1'b0, t[3:0]};
    end
    return 5'h10;
  endfunction

  // {known, decoded byte} for the simple escapes
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    case (c)
      8'h61:     esc_map = {1'b1, 8'd7};
      8'h62:     esc_map = {1'b1, 8'd8};
      8'h66:     esc_map = {1'b1, 8'd12};
      8'h6e:     esc_map = {1'b1, 8'd10};
      8'h72:     esc_map = {1'b1, 8'd13};
      8'h74:     esc_map = {1'b1, 8'd9};
      CH_BSLASH: esc_map = {1'b1, c};
      CH_SQUOTE: esc_map = {1'b1, c};
      CH_DQUOTE: esc_map = {1'b1, c};
      default:   esc_map = 9'd0;
    endcase
  endfunction

endpackage

FILE: rtl/sat_if.sv
// Valid/ready channel interfaces for buffer bytes and tokenizer results.
// Depends on nothing.
interface sat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;
  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface sat_out_if #(parameter int POS_WIDTH = 16);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [7:0]           arg_byte;
  logic [POS_WIDTH-1:0] position;
  logic                 last_of_run;
  modport source (output valid, output kind, output arg_byte, output position,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input arg_byte, input position,
                  input last_of_run, output ready);
endinterface

FILE: rtl/sat_front.sv
// Front end: accepts buffer bytes, runs the mode stack and builds the results of each item.
// Depends on sat_pkg and sat_in_if.
module sat_front #(
  parameter int POS_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  sat_in_if.sink                bytes,
  input  sat_pkg::qstat_t       qstat,
  output logic                  push,
  output sat_pkg::bundle_t      bundle,
  output logic [POS_WIDTH-1:0]  pos_out
);

  logic [2:0]           stk [sat_pkg::STACK_DEPTH];
  logic [2:0]           stk_next [sat_pkg::STACK_DEPTH];
  logic [2:0]           height, height_next;
  logic [7:0]           acc, acc_next;
  logic                 nonempty, nonempty_next;
  logic [POS_WIDTH-1:0] pos, pos_next;
  logic                 discarding, discarding_next;

  logic       accept;
  logic [7:0] c;
  logic [2:0] m, m_after;
  logic       pop, pa_en, pb_en, emit, argend, bad;
  logic [2:0] pa, pb;
  logic [7:0] eb;
  logic [4:0] hv;
  logic [8:0] em;
  logic [1:0] cnt;
  logic [2:0][1:0] kinds;

  assign bytes.ready = !qstat.full;
  assign accept      = bytes.valid && bytes.ready;
  assign c           = bytes.in_byte;
  assign m           = stk[height - 3'd1];
  assign hv          = sat_pkg::hex_val(c);
  assign em          = sat_pkg::esc_map(c);

  // Classify the byte against the top mode
  always_comb begin
    pop = 1'b0; pa_en = 1'b0; pb_en = 1'b0; emit = 1'b0; argend = 1'b0; bad = 1'b0;
    pa = sat_pkg::M_SKIPWS; pb = sat_pkg::M_SKIPWS; eb = c;
    acc_next = acc; nonempty_next = nonempty;
    case (m)
      sat_pkg::M_SKIPWS: begin
        if (!sat_pkg::is_space(c)) begin
          pa_en = 1'b1; pa = sat_pkg::M_ARG; nonempty_next = 1'b0;
          if (c == sat_pkg::CH_SQUOTE) begin
            pb_en = 1'b1; pb = sat_pkg::M_SQUOTE;
          end else if (c == sat_pkg::CH_DQUOTE) begin
            pb_en = 1'b1; pb = sat_pkg::M_DQUOTE;
          end else if (c == sat_pkg::CH_BSLASH) begin
            pb_en = 1'b1; pb = sat_pkg::M_ESC;
          end else begin
            emit = 1'b1;
          end
        end
      end
      sat_pkg::M_SQUOTE, sat_pkg::M_DQUOTE: begin
        if (c == ((m == sat_pkg::M_SQUOTE) ? sat_pkg::CH_SQUOTE : sat_pkg::CH_DQUOTE)) begin
          pop = 1'b1;
        end else if (c == sat_pkg::CH_BSLASH) begin
          pa_en = 1'b1; pa = sat_pkg::M_ESC;
        end else begin
          emit = 1'b1;
        end
      end
      sat_pkg::M_ESC: begin
        pop = 1'b1;
        if (em[8]) begin
          emit = 1'b1; eb = em[7:0];
        end else if (c == sat_pkg::CH_X) begin
          pa_en = 1'b1; pa = sat_pkg::M_HEXLO;
          pb_en = 1'b1; pb = sat_pkg::M_HEXHI;
        end
      end
      sat_pkg::M_HEXHI: begin
        pop = 1'b1;
        if (hv[4]) bad = 1'b1;
        else acc_next = {hv[3:0], 4'd0};
      end
      sat_pkg::M_HEXLO: begin
        pop = 1'b1;
        if (hv[4]) begin
          bad = 1'b1;
        end else begin
          emit = 1'b1; eb = acc | {4'd0, hv[3:0] & sat_pkg::NIBBLE}; acc_next = 8'd0;
        end
      end
      default: begin
        if (sat_pkg::is_space(c)) begin
          argend = 1'b1; nonempty_next = 1'b0; pop = 1'b1;
        end else if (c == sat_pkg::CH_SQUOTE) begin
          pa_en = 1'b1; pa = sat_pkg::M_SQUOTE;
        end else if (c == sat_pkg::CH_DQUOTE) begin
          pa_en = 1'b1; pa = sat_pkg::M_DQUOTE;
        end else if (c == sat_pkg::CH_BSLASH) begin
          pa_en = 1'b1; pa = sat_pkg::M_ESC;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
    if (emit) nonempty_next = 1'b1;
    // a discarding buffer leaves the mode state alone
    if (discarding) begin
      pop = 1'b0; pa_en = 1'b0; pb_en = 1'b0; emit = 1'b0; argend = 1'b0; bad = 1'b0;
      acc_next = acc; nonempty_next = nonempty;
    end
  end

  // Stack update: pop first, then up to two pushes
  always_comb begin
    stk_next    = stk;
    height_next = height;
    if (pop && height_next > 3'd1) height_next = height_next - 3'd1;
    if (pa_en && height_next < 3'(sat_pkg::STACK_DEPTH)) begin
      stk_next[height_next] = pa;
      height_next = height_next + 3'd1;
    end
    if (pb_en && height_next < 3'(sat_pkg::STACK_DEPTH)) begin
      stk_next[height_next] = pb;
      height_next = height_next + 3'd1;
    end
    m_after = stk_next[height_next - 3'd1];
  end

  always_comb begin
    pos_next        = pos;
    discarding_next = discarding | bad;
    if (!discarding && !bad && pos != {POS_WIDTH{1'b1}}) pos_next = pos + POS_WIDTH'(1);
  end

  // Result list of this item
  always_comb begin
    cnt   = 2'd0;
    kinds = '0;
    if (emit) begin
      kinds[cnt] = sat_pkg::K_BYTE; cnt = cnt + 2'd1;
    end
    if (argend) begin
      kinds[cnt] = sat_pkg::K_ARGEND; cnt = cnt + 2'd1;
    end
    if (bad) begin
      kinds[cnt] = sat_pkg::K_BADHEX; cnt = cnt + 2'd1;
    end
    if (bytes.end_of_buffer) begin
      if (!discarding_next && m_after == sat_pkg::M_ARG && nonempty_next) begin
        kinds[cnt] = sat_pkg::K_ARGEND; cnt = cnt + 2'd1;
      end
      kinds[cnt] = sat_pkg::K_DONE; cnt = cnt + 2'd1;
    end
    bundle.cnt   = cnt;
    bundle.kinds = kinds;
    bundle.data  = eb;
  end

  assign push    = accept && (cnt != 2'd0);
  assign pos_out = pos_next;

  always_ff @(posedge clk) begin
    if (rst || (accept && bytes.end_of_buffer)) begin
      for (int i = 0; i < sat_pkg::STACK_DEPTH; i++) stk[i] <= sat_pkg::M_SKIPWS;
      height     <= 3'd1;
      acc        <= 8'd0;
      nonempty   <= 1'b0;
      pos        <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      stk        <= stk_next;
      height     <= height_next;
      acc        <= acc_next;
      nonempty   <= nonempty_next;
      pos        <= pos_next;
      discarding <= discarding_next;
    end
  end

endmodule

FILE: rtl/sat_queue.sv
// Short queue of per-item result bundles between front and back.
// Depends on sat_pkg.
module sat_queue #(
  parameter int W = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [W-1:0]    wdata,
  input  logic            pop,
  output logic [W-1:0]    rdata,
  output sat_pkg::qstat_t qstat
);

  logic [W-1:0]            mem [sat_pkg::QDEPTH];
  logic [sat_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [sat_pkg::QAW:0]   fill;

  assign qstat.full     = (fill == (sat_pkg::QAW+1)'(sat_pkg::QDEPTH));
  assign qstat.nonempty = (fill != '0);
  assign rdata          = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + (sat_pkg::QAW)'(1);
      if (pop)  rd_ptr <= rd_ptr + (sat_pkg::QAW)'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (sat_pkg::QAW+1)'(1);
        2'b01:   fill <= fill - (sat_pkg::QAW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/sat_back.sv
// Back end: walks the head bundle of the queue and hands out one result per handshake.
// Depends on sat_pkg and sat_out_if.
module sat_back #(
  parameter int POS_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sat_pkg::bundle_t     head,
  input  logic [POS_WIDTH-1:0] head_pos,
  input  sat_pkg::qstat_t      qstat,
  output logic                 pop,
  sat_out_if.source            results
);

  logic [1:0] idx;
  logic [1:0] kind;
  logic       last;

  assign kind = head.kinds[idx];
  assign last = (idx == head.cnt - 2'd1);

  assign results.valid       = qstat.nonempty;
  assign results.kind        = kind;
  assign results.arg_byte    = (kind == sat_pkg::K_BYTE) ? head.data : 8'd0;
  assign results.position    = (kind == sat_pkg::K_BADHEX || kind == sat_pkg::K_DONE) ?
                               head_pos : '0;
  assign results.last_of_run = last;

  assign pop = results.valid && results.ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (results.valid && results.ready) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

FILE: rtl/shell_argument_tokenizer.sv
// Shell argument tokenizer: splits a byte stream into arguments with quotes and escapes.
// An item's results are queued when it is accepted and offered in order from the queue.
// Throughput: one byte per cycle in while the queue is not full; one result per cycle
// out when ready; the four-bundle queue absorbs items with two or three results.
// Reset: synchronous; clears the mode stack, counters and queue pointers.
// Depends on sat_pkg, sat_if, sat_front, sat_queue and sat_back.
module shell_argument_tokenizer #(
  parameter int POS_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  sat_in_if.sink    bytes,
  sat_out_if.source results
);

  localparam int QW = $bits(sat_pkg::bundle_t) + POS_WIDTH;

  sat_pkg::qstat_t      qstat;
  sat_pkg::bundle_t     fb, hb;
  logic [POS_WIDTH-1:0] fpos, hpos;
  logic                 push, pop;
  logic [QW-1:0]        qhead;

  sat_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes),
    .qstat   (qstat),
    .push    (push),
    .bundle  (fb),
    .pos_out (fpos)
  );

  sat_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({fb, fpos}),
    .pop   (pop),
    .rdata (qhead),
    .qstat (qstat)
  );

  assign hb   = qhead[QW-1:POS_WIDTH];
  assign hpos = qhead[POS_WIDTH-1:0];

  sat_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (hb),
    .head_pos (hpos),
    .qstat    (qstat),
    .pop      (pop),
    .results  (results)
  );

  // Every end of buffer queues a bundle that closes with a done mark
  a_eob_done: assert property (@(posedge clk) disable iff (rst)
    bytes.valid && bytes.ready && bytes.end_of_buffer |->
      push && fb.kinds[fb.cnt - 2'd1] == sat_pkg::K_DONE)
    else $error("end of buffer without done mark");

  // Nothing queued is ever an empty bundle
  a_push_cnt: assert property (@(posedge clk) disable iff (rst)
    push |-> fb.cnt != 2'd0)
    else $error("empty bundle queued");

  // A done mark always closes the run of its item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == sat_pkg::K_DONE |-> results.last_of_run)
    else $error("done mark not last of run");

  // A pop only follows a completed handshake on the final result
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.nonempty && results.last_of_run)
    else $error("queue popped mid bundle");

endmodule

FILE: sim/shell_argument_tokenizer_tb.sv
// Self-checking testbench for shell_argument_tokenizer: byte stream in, token results out.
// Needs sat_pkg, sat_if and the tokenizer RTL; predicts every result and compares in order.
`timescale 1ns / 1ps

module shell_argument_tokenizer_tb;

  localparam int POS_W        = 16;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 1500;
  localparam int RANDOM_GOAL  = 225;

  typedef struct packed {
    logic [7:0] ch;
    logic       eob;
  } buf_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       arg_byte;
    logic [POS_W-1:0] position;
    logic             last_of_run;
  } token_t;

  logic clk;
  logic rst;

  sat_in_if                      bytes_ch ();
  sat_out_if #(.POS_WIDTH(POS_W)) res_ch ();

  shell_argument_tokenizer #(.POS_WIDTH(POS_W)) DUT (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_ch),
    .results (res_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Tokenizer shadow state
  sat_pkg::mode_t   mode_stack [sat_pkg::STACK_DEPTH];
  int               stack_h;
  logic [7:0]       hex_high;
  logic             arg_has_bytes;
  logic [POS_W-1:0] pos_count;
  logic             skipping;
  token_t           burst [3];
  int               burst_n;

  token_t    expected_tokens [$];
  buf_item_t pending_items [$];
  logic [7:0] draft [$];

  int items_taken = 0;
  int items_shown = -1;
  int cycle_count = 0;
  int mismatches  = 0;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Bit 4 flags a non-hex character
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic sat_pkg::mode_t top_mode();
    return mode_stack[stack_h-1];
  endfunction

  task automatic clear_state();
    foreach (mode_stack[i]) mode_stack[i] = sat_pkg::M_SKIPWS;
    stack_h       = 1;
    hex_high      = 8'd0;
    arg_has_bytes = 1'b0;
    pos_count     = '0;
    skipping      = 1'b0;
  endtask

  task automatic push_mode(input sat_pkg::mode_t m);
    if (stack_h < sat_pkg::STACK_DEPTH) begin
      mode_stack[stack_h] = m;
      stack_h++;
    end
  endtask

  task automatic pop_mode();
    if (stack_h > 1) stack_h--;
  endtask

  task automatic emit(input logic [1:0] k, input logic [7:0] b, input logic [POS_W-1:0] p);
    if (burst_n < 3) begin
      burst[burst_n].kind        = k;
      burst[burst_n].arg_byte    = b;
      burst[burst_n].position    = p;
      burst[burst_n].last_of_run = 1'b0;
      burst_n++;
    end
  endtask

  task automatic emit_char(input logic [7:0] c);
    emit(sat_pkg::K_BYTE, c, '0);
    arg_has_bytes = 1'b1;
  endtask

  task automatic advance_char(input logic [7:0] c, output logic ok);
    sat_pkg::mode_t m;
    logic [4:0]     d;
    ok = 1'b1;
    m  = top_mode();
    d  = hex_nibble(c);
    case (m)
      sat_pkg::M_SKIPWS: begin
        if (!is_blank(c)) begin
          push_mode(sat_pkg::M_ARG);
          arg_has_bytes = 1'b0;
          if (c == sat_pkg::CH_SQUOTE) push_mode(sat_pkg::M_SQUOTE);
          else if (c == sat_pkg::CH_DQUOTE) push_mode(sat_pkg::M_DQUOTE);
          else if (c == sat_pkg::CH_BSLASH) push_mode(sat_pkg::M_ESC);
          else emit_char(c);
        end
      end
      sat_pkg::M_SQUOTE, sat_pkg::M_DQUOTE: begin
        if (c == ((m == sat_pkg::M_SQUOTE) ? sat_pkg::CH_SQUOTE : sat_pkg::CH_DQUOTE))
          pop_mode();
        else if (c == sat_pkg::CH_BSLASH) push_mode(sat_pkg::M_ESC);
        else emit_char(c);
      end
      sat_pkg::M_ESC: begin
        pop_mode();
        case (c)
          "a": emit_char(8'd7);
          "b": emit_char(8'd8);
          "f": emit_char(8'd12);
          "n": emit_char(8'd10);
          "r": emit_char(8'd13);
          "t": emit_char(8'd9);
          sat_pkg::CH_BSLASH, sat_pkg::CH_SQUOTE, sat_pkg::CH_DQUOTE: emit_char(c);
          sat_pkg::CH_X: begin
            push_mode(sat_pkg::M_HEXLO);
            push_mode(sat_pkg::M_HEXHI);
          end
          default: ; // unknown escape: byte dropped
        endcase
      end
      sat_pkg::M_HEXHI: begin
        pop_mode();
        if (d[4]) ok = 1'b0;
        else hex_high = {d[3:0], 4'h0};
      end
      sat_pkg::M_HEXLO: begin
        pop_mode();
        if (d[4]) ok = 1'b0;
        else begin
          emit_char(hex_high | {4'h0, d[3:0]});
          hex_high = 8'd0;
        end
      end
      default: begin
        if (is_blank(c)) begin
          emit(sat_pkg::K_ARGEND, 8'd0, '0);
          arg_has_bytes = 1'b0;
          pop_mode();
        end else if (c == sat_pkg::CH_SQUOTE) push_mode(sat_pkg::M_SQUOTE);
        else if (c == sat_pkg::CH_DQUOTE) push_mode(sat_pkg::M_DQUOTE);
        else if (c == sat_pkg::CH_BSLASH) push_mode(sat_pkg::M_ESC);
        else emit_char(c);
      end
    endcase
  endtask

  task automatic tokenize_item(input logic [7:0] c, input logic eob);
    logic   ok;
    token_t t;
    burst_n = 0;
    if (!skipping) begin
      advance_char(c, ok);
      if (ok) begin
        if (pos_count != '1) pos_count++;
      end else begin
        emit(sat_pkg::K_BADHEX, 8'd0, pos_count);
        skipping = 1'b1;
      end
    end
    if (eob) begin
      // unterminated quotes and escapes get no argument end
      if (!skipping && top_mode() == sat_pkg::M_ARG && arg_has_bytes)
        emit(sat_pkg::K_ARGEND, 8'd0, '0);
      emit(sat_pkg::K_DONE, 8'd0, pos_count);
      clear_state();
    end
    for (int i = 0; i < burst_n; i++) begin
      t             = burst[i];
      t.last_of_run = (i == burst_n - 1);
      expected_tokens.insert(expected_tokens.size(), t);
    end
  endtask

  // Stimulus construction

  task automatic put_char(input logic [7:0] c);
    draft.insert(draft.size(), c);
  endtask

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'd32 : 8'd9 + r[7:0];
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (is_blank(c) || c == sat_pkg::CH_SQUOTE || c == sat_pkg::CH_DQUOTE ||
           c == sat_pkg::CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + {4'h0, v};
    return ($urandom_range(1) ? "a" : "A") + {4'h0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] d;
    do begin
      c = 8'($urandom_range(255));
      d = hex_nibble(c);
    end while (!d[4]);
    return c;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic commit_buffer();
    buf_item_t it;
    foreach (draft[i]) begin
      it.ch  = draft[i];
      it.eob = (i == draft.size() - 1);
      pending_items.insert(pending_items.size(), it);
    end
    draft.delete();
  endtask

  task automatic add_escape();
    string      simple;
    logic [7:0] c;
    int         r;
    simple = "abfnrt\\'\"";
    put_char(sat_pkg::CH_BSLASH);
    r = $urandom_range(9);
    if (r < 6) put_char(simple[$urandom_range(simple.len() - 1)]);
    else if (r < 8) begin
      put_char(sat_pkg::CH_X);
      put_char(hex_char(4'($urandom_range(15))));
      put_char(hex_char(4'($urandom_range(15))));
    end else begin
      do c = 8'($urandom_range(255));
      while (c == sat_pkg::CH_X || c == sat_pkg::CH_BSLASH || c == sat_pkg::CH_SQUOTE ||
             c == sat_pkg::CH_DQUOTE ||
             c == "a" || c == "b" || c == "f" || c == "n" || c == "r" || c == "t");
      put_char(c);
    end
  endtask

  task automatic add_quoted(input logic [7:0] q);
    logic [7:0] c;
    int         n;
    put_char(q);
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) add_escape();
      else begin
        do c = 8'($urandom_range(255));
        while (c == q || c == sat_pkg::CH_BSLASH);
        put_char(c);
      end
    end
    put_char(q);
  endtask

  task automatic add_word();
    int segs;
    int r;
    segs = $urandom_range(1, 4);
    for (int i = 0; i < segs; i++) begin
      r = $urandom_range(9);
      if (r < 4) repeat ($urandom_range(1, 3)) put_char(plain_char());
      else if (r < 6) add_quoted(sat_pkg::CH_SQUOTE);
      else if (r < 8) add_quoted(sat_pkg::CH_DQUOTE);
      else add_escape();
    end
  endtask

  task automatic add_gap();
    repeat ($urandom_range(1, 2)) put_char(blank_char());
  endtask

  task automatic random_buffer();
    int r;
    r = $urandom_range(9);
    if (r < 7) begin
      if ($urandom_range(3) == 0) add_gap();
      repeat ($urandom_range(1, 3)) begin
        add_word();
        add_gap();
      end
      // usually drop one trailing blank, which can leave the buffer ending on the last word
      if ($urandom_range(2) != 0) void'(draft.pop_back());
      if (draft.size() == 0) put_char(plain_char());
    end else if (r == 7) begin
      add_word();
      add_gap();
      put_char(sat_pkg::CH_BSLASH);
      put_char(sat_pkg::CH_X);
      if ($urandom_range(1)) put_char(hex_char(4'($urandom_range(15))));
      put_char(non_hex_char());
      add_word();
    end else if (r == 8) begin
      add_word();
      add_gap();
      case ($urandom_range(3))
        0: put_char(sat_pkg::CH_SQUOTE);
        1: put_char(sat_pkg::CH_DQUOTE);
        2: ;
        default: put_char(sat_pkg::CH_X);
      endcase
      put_char(plain_char());
      put_char(sat_pkg::CH_BSLASH);
    end else begin
      repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(255)));
    end
    commit_buffer();
  endtask

  function automatic logic take_break();
    return ($urandom_range(99) < 34) && !(cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);
  endfunction

  // Driver: new input and ready values at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      bytes_ch.valid <= 1'b0;
      res_ch.ready   <= 1'b0;
    end else begin
      res_ch.ready <= !take_break();
      if (!(bytes_ch.valid && items_shown == items_taken)) begin
        if (items_taken < pending_items.size() && !take_break()) begin
          bytes_ch.valid         <= 1'b1;
          bytes_ch.in_byte       <= pending_items[items_taken].ch;
          bytes_ch.end_of_buffer <= pending_items[items_taken].eob;
          items_shown = items_taken;
        end else begin
          bytes_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: results checked and items predicted at the rising edge
  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind        = res_ch.kind;
        got.arg_byte    = res_ch.arg_byte;
        got.position    = res_ch.position;
        got.last_of_run = res_ch.last_of_run;
        if (expected_tokens.size() == 0) begin
          $display("%0t: expected no result, got kind %0d byte %0h position %0d last %0b",
                   $time, got.kind, got.arg_byte, got.position, got.last_of_run);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind != want.kind) begin
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
            mismatches++;
          end
          if (got.arg_byte != want.arg_byte) begin
            $display("%0t: arg_byte expected %0h, got %0h", $time, want.arg_byte, got.arg_byte);
            mismatches++;
          end
          if (got.position != want.position) begin
            $display("%0t: position expected %0d, got %0d", $time, want.position, got.position);
            mismatches++;
          end
          if (got.last_of_run != want.last_of_run) begin
            $display("%0t: last_of_run expected %0b, got %0b", $time,
                     want.last_of_run, got.last_of_run);
            mismatches++;
          end
        end
      end
      if (bytes_ch.valid && bytes_ch.ready) begin
        tokenize_item(bytes_ch.in_byte, bytes_ch.end_of_buffer);
        items_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int random_count;
    int base;
    bytes_ch.valid         = 1'b0;
    bytes_ch.in_byte       = 8'd0;
    bytes_ch.end_of_buffer = 1'b0;
    res_ch.ready           = 1'b0;
    rst                    = 1'b1;
    clear_state();

    // extreme bytes closed by a vertical tab
    put_char(8'h00);
    put_char(8'hff);
    put_char(8'h0b);
    commit_buffer();
    // escape inside single quotes
    add_text("'\\n'");
    commit_buffer();
    // hex escape, lower and upper case digits, inside double quotes
    add_text("\"\\xaF\"");
    commit_buffer();
    // unknown escape leaves an empty argument
    add_text("\\q ");
    commit_buffer();
    // bad hex digit, rest of buffer discarded
    add_text("\\xgzz");
    commit_buffer();
    // quote left open at end of buffer
    add_text("\"ab");
    commit_buffer();

    random_count = 0;
    while (random_count < RANDOM_GOAL) begin
      base = pending_items.size();
      random_buffer();
      random_count += pending_items.size() - base;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_taken < pending_items.size() || expected_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
